FILE: hdl/mono_bitmap_pixel_expander_top_defines.svh
// Assertion macros shared by the checker.
`ifndef MONO_BITMAP_PIXEL_EXPANDER_TOP_DEFINES_SVH
`define MONO_BITMAP_PIXEL_EXPANDER_TOP_DEFINES_SVH

// Condition holds in the same cycle as the trigger.
`define MBPE_ASSERT_NOW(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("assertion failed");

// Condition holds in the cycle after the trigger.
`define MBPE_ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("assertion failed");

`endif

FILE: hdl/mbpe_pkg.sv
`default_nettype none
package mbpe_pkg;

   localparam int SCREEN_WIDTH_DEFAULT  = 128;
   localparam int SCREEN_HEIGHT_DEFAULT = 64;

   localparam int BYTE_BITS  = 8;
   localparam int PIX_BITS   = $clog2(BYTE_BITS);
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_ORIGIN   = 2'd1,
      STATUS_SIZE     = 2'd2,
      STATUS_MISMATCH = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CSR_ORIGIN_X   = 3'd0,
      CSR_ORIGIN_Y   = 3'd1,
      CSR_BMP_WIDTH  = 3'd2,
      CSR_BMP_HEIGHT = 3'd3,
      CSR_BYTE_COUNT = 3'd4,
      CSR_FG_COLOR   = 3'd5,
      CSR_BG_COLOR   = 3'd6,
      CSR_VERTICAL   = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [9:0]  origin_x;
      logic [9:0]  origin_y;
      logic [9:0]  bmp_width;
      logic [9:0]  bmp_height;
      logic [15:0] byte_count;
      logic [1:0]  fg_color;
      logic [1:0]  bg_color;
      logic        vertical;
   } cfg_type;

   // One classified word on its way from the front to the back.
   typedef struct packed {
      logic [7:0]  data_byte;
      logic [10:0] base_x;
      logic [10:0] base_y;
      status_type  status;
   } entry_type;

endpackage
`default_nettype wire

FILE: hdl/mbpe_front.sv
`default_nettype none
module mbpe_front
   import mbpe_pkg::*;
#(
   parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEFAULT,
   parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEFAULT
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire cfg_type   cfg,
   input  wire logic      accept,
   input  wire logic [7:0] data_byte,
   output entry_type      entry
);

   localparam logic signed [11:0] SW_S = 12'(SCREEN_WIDTH);
   localparam logic signed [11:0] SH_S = 12'(SCREEN_HEIGHT);
   localparam logic [10:0]        SW_U = 11'(SCREEN_WIDTH);
   localparam logic [10:0]        SH_U = 11'(SCREEN_HEIGHT);

   logic [9:0]  column_pos_ff, column_pos_in;
   logic [9:0]  row_pos_ff, row_pos_in;
   logic [15:0] bytes_taken_ff, bytes_taken_in;

   logic signed [11:0] ox_s, oy_s;
   logic [9:0]  mul_a, mul_b;
   logic [19:0] need;
   logic [10:0] next_col;
   logic [15:0] taken_inc;
   status_type  status;

   always_comb begin
      ox_s = signed'({{2{cfg.origin_x[9]}}, cfg.origin_x});
      oy_s = signed'({{2{cfg.origin_y[9]}}, cfg.origin_y});
      mul_a = cfg.vertical ? cfg.bmp_width : {3'b000, cfg.bmp_width[9:3]};
      mul_b = cfg.vertical ? {3'b000, cfg.bmp_height[9:3]} : cfg.bmp_height;
      need = {10'd0, mul_a} * {10'd0, mul_b};
      if (ox_s > SW_S || oy_s > SH_S) begin
         status = STATUS_ORIGIN;
      end else if ({1'b0, cfg.bmp_width} > SW_U || {1'b0, cfg.bmp_height} > SH_U) begin
         status = STATUS_SIZE;
      end else if (cfg.vertical ? (cfg.bmp_height[2:0] != 3'd0)
                                : (cfg.bmp_width[2:0] != 3'd0)) begin
         status = STATUS_MISMATCH;
      end else if (need != {4'd0, cfg.byte_count}) begin
         status = STATUS_MISMATCH;
      end else begin
         status = STATUS_OK;
      end

      entry.data_byte = data_byte;
      entry.base_x    = {cfg.origin_x[9], cfg.origin_x} + {1'b0, column_pos_ff};
      entry.base_y    = {cfg.origin_y[9], cfg.origin_y} + {1'b0, row_pos_ff};
      entry.status    = status;

      // Bitmap position of the following word; wraps at the row end and the bitmap end.
      next_col  = {1'b0, column_pos_ff} + (cfg.vertical ? 11'd1 : 11'(BYTE_BITS));
      taken_inc = bytes_taken_ff + 16'd1;
      column_pos_in  = column_pos_ff;
      row_pos_in     = row_pos_ff;
      bytes_taken_in = bytes_taken_ff;
      if (accept && status == STATUS_OK) begin
         if (next_col >= {1'b0, cfg.bmp_width}) begin
            column_pos_in = '0;
            row_pos_in    = row_pos_ff + (cfg.vertical ? 10'(BYTE_BITS) : 10'd1);
         end else begin
            column_pos_in = next_col[9:0];
         end
         bytes_taken_in = taken_inc;
         if (taken_inc >= cfg.byte_count) begin
            column_pos_in  = '0;
            row_pos_in     = '0;
            bytes_taken_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_pos_ff  <= '0;
         row_pos_ff     <= '0;
         bytes_taken_ff <= '0;
      end else begin
         column_pos_ff  <= column_pos_in;
         row_pos_ff     <= row_pos_in;
         bytes_taken_ff <= bytes_taken_in;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/mbpe_queue.sv
`default_nettype none
module mbpe_queue
   import mbpe_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type wr_entry,
   output logic           full,
   input  wire logic      pop,
   output logic           rd_valid,
   output entry_type      rd_entry
);

   entry_type               slots_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]       count_ff, count_in;

   always_comb begin
      full     = (count_ff == (QUEUE_AW + 1)'(QUEUE_DEPTH));
      rd_valid = (count_ff != '0);
      rd_entry = slots_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/mbpe_back.sv
`default_nettype none
module mbpe_back
   import mbpe_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire cfg_type   cfg,
   input  wire logic      head_valid,
   input  wire entry_type head,
   output logic           head_pop,
   output logic           rsp_empty,
   input  wire logic      rsp_pop,
   output logic [10:0]    rsp_pixel_x,
   output logic [10:0]    rsp_pixel_y,
   output logic [1:0]     rsp_pixel_color,
   output logic [1:0]     rsp_status,
   output logic           rsp_last_of_byte
);

   logic                rsp_valid_ff, rsp_valid_in;
   logic [PIX_BITS-1:0] pix_ff, pix_in;
   logic [10:0]         x_ff, x_in;
   logic [10:0]         y_ff, y_in;
   logic [1:0]          color_ff, color_in;
   logic [1:0]          status_ff, status_in;
   logic                last_ff, last_in;

   logic                load;
   logic                is_err;
   logic                bit_val;
   logic [PIX_BITS-1:0] bit_sel;

   always_comb begin
      // The output register is refilled when the queue head holds a word and the register is free or being emptied.
      load    = head_valid && (!rsp_valid_ff || rsp_pop);
      is_err  = (head.status != STATUS_OK);
      bit_sel = cfg.vertical ? pix_ff : PIX_BITS'(BYTE_BITS - 1) - pix_ff;
      bit_val = head.data_byte[bit_sel];

      rsp_valid_in = rsp_valid_ff;
      if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end

      if (is_err) begin
         x_in     = '0;
         y_in     = '0;
         color_in = '0;
         last_in  = 1'b1;
      end else begin
         x_in     = cfg.vertical ? head.base_x : head.base_x + 11'(pix_ff);
         y_in     = cfg.vertical ? head.base_y + 11'(pix_ff) : head.base_y;
         color_in = bit_val ? cfg.fg_color : cfg.bg_color;
         last_in  = (pix_ff == PIX_BITS'(BYTE_BITS - 1));
      end
      status_in = head.status;

      head_pop = load && last_in;
      pix_in   = pix_ff;
      if (load) begin
         pix_in = last_in ? '0 : pix_ff + 1'b1;
      end

      rsp_empty        = !rsp_valid_ff;
      rsp_pixel_x      = x_ff;
      rsp_pixel_y      = y_ff;
      rsp_pixel_color  = color_ff;
      rsp_status       = status_ff;
      rsp_last_of_byte = last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pix_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         pix_ff       <= pix_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         x_ff      <= x_in;
         y_ff      <= y_in;
         color_ff  <= color_in;
         status_ff <= status_in;
         last_ff   <= last_in;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/mono_bitmap_pixel_expander_top.sv
// Channel   Direction  Handshake          Payload
// req_      in         push / full        data_byte
// rsp_      out        empty / pop        pixel_x, pixel_y, pixel_color, status, last_of_byte
// csr_      in         write              index, wdata
//
// A good word yields eight pixel words, one per cycle from the output register while
// rsp_pop keeps it emptied; a word with a bad setup yields one error word.
// A word enters the two-entry queue in the cycle it is pushed; its first result
// is loaded into the output register once that register is free or being emptied.
// Reset clears the position counters, the queue and the output, and loads the
// register defaults. The input takes words while the queue has room, also while
// pop is held low.
`default_nettype none
module mono_bitmap_pixel_expander_top
   import mbpe_pkg::*;
#(
   parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEFAULT,
   parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [10:0]      rsp_pixel_x,
   output logic [10:0]      rsp_pixel_y,
   output logic [1:0]       rsp_pixel_color,
   output logic [1:0]       rsp_status,
   output logic             rsp_last_of_byte,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   cfg_type   cfg_ff, cfg_in;
   entry_type front_entry, head_entry;
   logic      accept, q_full, head_valid, head_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_ORIGIN_X:   cfg_in.origin_x   = csr_wdata[9:0];
            CSR_ORIGIN_Y:   cfg_in.origin_y   = csr_wdata[9:0];
            CSR_BMP_WIDTH:  cfg_in.bmp_width  = csr_wdata[9:0];
            CSR_BMP_HEIGHT: cfg_in.bmp_height = csr_wdata[9:0];
            CSR_BYTE_COUNT: cfg_in.byte_count = csr_wdata;
            CSR_FG_COLOR:   cfg_in.fg_color   = csr_wdata[1:0];
            CSR_BG_COLOR:   cfg_in.bg_color   = csr_wdata[1:0];
            CSR_VERTICAL:   cfg_in.vertical   = csr_wdata[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
      req_full = q_full;
      accept   = req_push && !q_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x   <= '0;
         cfg_ff.origin_y   <= '0;
         cfg_ff.bmp_width  <= 10'd8;
         cfg_ff.bmp_height <= 10'd8;
         cfg_ff.byte_count <= 16'd8;
         cfg_ff.fg_color   <= 2'd1;
         cfg_ff.bg_color   <= 2'd0;
         cfg_ff.vertical   <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mbpe_front #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .accept    (accept),
      .data_byte (req_data_byte),
      .entry     (front_entry)
   );

   mbpe_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .wr_entry (front_entry),
      .full     (q_full),
      .pop      (head_pop),
      .rd_valid (head_valid),
      .rd_entry (head_entry)
   );

   mbpe_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .head_valid       (head_valid),
      .head             (head_entry),
      .head_pop         (head_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_pixel_color  (rsp_pixel_color),
      .rsp_status       (rsp_status),
      .rsp_last_of_byte (rsp_last_of_byte)
   );

endmodule
`default_nettype wire

FILE: hdl/mbpe_checker.sv
`default_nettype none
`include "mono_bitmap_pixel_expander_top_defines.svh"
module mbpe_checker
   import mbpe_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_empty,
   input wire logic        rsp_pop,
   input wire logic [10:0] rsp_pixel_x,
   input wire logic [10:0] rsp_pixel_y,
   input wire logic [1:0]  rsp_pixel_color,
   input wire logic [1:0]  rsp_status,
   input wire logic        rsp_last_of_byte
);

   logic        shown, err_word, mid_pop, err_clean;
   logic [26:0] rsp_word;
   logic [21:0] pos, step_x, step_y;

   always_comb begin
      shown     = !rsp_empty;
      err_word  = shown && (rsp_status != STATUS_OK);
      mid_pop   = shown && rsp_pop && (rsp_status == STATUS_OK) && !rsp_last_of_byte;
      err_clean = rsp_last_of_byte && (rsp_pixel_x == 11'd0) && (rsp_pixel_y == 11'd0)
                  && (rsp_pixel_color == 2'd0);
      rsp_word  = {rsp_pixel_x, rsp_pixel_y, rsp_pixel_color, rsp_status, rsp_last_of_byte};
      pos       = {rsp_pixel_x, rsp_pixel_y};
      step_x    = {rsp_pixel_x + 11'd1, rsp_pixel_y};
      step_y    = {rsp_pixel_x, rsp_pixel_y + 11'd1};
   end

   // An error word carries no pixel and closes its input word.
   `MBPE_ASSERT_NOW(a_err_form, clock, reset, err_word, err_clean)

   // A result that waits holds its value.
   `MBPE_ASSERT_NEXT(a_hold, clock, reset, shown && !rsp_pop, !rsp_empty && $stable(rsp_word))

   // The rest of an input word follows without a gap and stays good.
   `MBPE_ASSERT_NEXT(a_no_gap, clock, reset, mid_pop, !rsp_empty && rsp_status == STATUS_OK)

   // Pixels of one input word step by one along a single axis.
   `MBPE_ASSERT_NEXT(a_step, clock, reset, mid_pop, pos == $past(step_x) || pos == $past(step_y))

endmodule

bind mono_bitmap_pixel_expander_top mbpe_checker u_checker (.*);
`default_nettype wire
